// File: src/sal_pkg.sv
// shared codes, widths and result word type for the lru tag store
package sal_pkg;

	// field widths fixed by the access and result words
	localparam int OP_W      = 2;
	localparam int SET_IDX_W = 6;
	localparam int TAG_IN_W  = 20;
	localparam int STATE_W   = 3;
	localparam int OUT_TAG_W = 20;

	// operation codes
	localparam logic [OP_W-1:0] OP_LOOKUP    = 2'd0;
	localparam logic [OP_W-1:0] OP_SET_STATE = 2'd1;
	localparam logic [OP_W-1:0] OP_TOUCH     = 2'd2;
	localparam logic [OP_W-1:0] OP_INSERT    = 2'd3;

	// moesi line states
	localparam logic [STATE_W-1:0] ST_INVALID  = 3'd0;
	localparam logic [STATE_W-1:0] ST_SHARED   = 3'd1;
	localparam logic [STATE_W-1:0] ST_EXCL     = 3'd2;
	localparam logic [STATE_W-1:0] ST_OWNED    = 3'd3;
	localparam logic [STATE_W-1:0] ST_MODIFIED = 3'd4;

	// result word of one access
	typedef struct packed {
		logic                 hit;
		logic [STATE_W-1:0]   found_state;
		logic                 victim_valid;
		logic [OUT_TAG_W-1:0] victim_tag;
		logic                 victim_dirty;
	} sal_result_t;

endpackage

// File: src/set_assoc_lru_tag_store_core.sv
// Tag store of a set-associative cache with true lru order per set and moesi
// line states. One access word is taken per clock cycle (start high while busy
// is low); its result word is formed in the update stage, registered and
// flagged by done for a single cycle; the receiver cannot hold results off.
// Each set is one row of a single-port-write, registered-read memory: the row
// is read on acceptance, updated in the following cycle and written back at its
// end, and a row just written is forwarded to an access of the same set that
// follows directly. After reset the block clears the memory one set per cycle
// and holds busy high until the last set is cleared; afterwards busy stays low.
module set_assoc_lru_tag_store_core #(
	parameter int NUM_SETS  = 64,
	parameter int NUM_WAYS  = 4,
	parameter int TAG_WIDTH = 20
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [sal_pkg::OP_W-1:0]        operation,
	input  logic [sal_pkg::SET_IDX_W-1:0]   set_index,
	input  logic [sal_pkg::TAG_IN_W-1:0]    line_tag,
	input  logic [sal_pkg::STATE_W-1:0]     new_state,
	output logic                            done,
	output logic                            hit,
	output logic [sal_pkg::STATE_W-1:0]     found_state,
	output logic                            victim_valid,
	output logic [sal_pkg::OUT_TAG_W-1:0]   victim_tag,
	output logic                            victim_dirty
);
	import sal_pkg::*;

	localparam int SET_AW  = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
	localparam int RANK_W  = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
	localparam int TAGS_W  = NUM_WAYS * TAG_WIDTH;
	localparam int STS_W   = NUM_WAYS * STATE_W;
	localparam int RANKS_W = NUM_WAYS * RANK_W;
	localparam int ROW_W   = TAGS_W + STS_W + RANKS_W;
	localparam int IDX_CNT = 2 ** SET_IDX_W;

	// set index folding table
	logic [SET_AW-1:0] set_lut [IDX_CNT];

	for (genvar g = 0; g < IDX_CNT; g++) begin : g_set_lut
		assign set_lut[g] = SET_AW'(g % NUM_SETS);
	end

	// row memory
	logic [ROW_W-1:0] row_mem [NUM_SETS];

	logic              accept;
	logic [SET_AW-1:0] rd_addr;
	logic              clr_active_q;
	logic [SET_AW-1:0] clr_addr_q;

	logic                     valid_s1;
	logic [OP_W-1:0]          op_s1;
	logic [TAG_WIDTH-1:0]     tag_s1;
	logic [STATE_W-1:0]       ns_s1;
	logic [SET_AW-1:0]        addr_s1;
	logic [ROW_W-1:0]         rd_row_s1;
	logic                     fwd_s1;
	logic [ROW_W-1:0]         fwd_row_s1;

	logic [ROW_W-1:0]         cur_row;
	logic [ROW_W-1:0]         upd_row;
	logic [ROW_W-1:0]         clr_row;
	logic                     mem_we;
	logic [SET_AW-1:0]        mem_waddr;
	logic [ROW_W-1:0]         mem_wdata;

	logic [NUM_WAYS-1:0][TAG_WIDTH-1:0] cur_tags;
	logic [NUM_WAYS-1:0][STATE_W-1:0]   cur_states;
	logic [NUM_WAYS-1:0][RANK_W-1:0]    cur_ranks;
	logic [NUM_WAYS-1:0][TAG_WIDTH-1:0] upd_tags;
	logic [NUM_WAYS-1:0][STATE_W-1:0]   upd_states;
	logic [NUM_WAYS-1:0][RANK_W-1:0]    upd_ranks;
	logic [NUM_WAYS-1:0][RANK_W-1:0]    clr_ranks;
	sal_result_t                        res;

	logic done_q;

	assign busy    = clr_active_q;
	assign accept  = start && !clr_active_q;
	assign rd_addr = set_lut[set_index];

	// reset row: all ways invalid, rank equal to way number
	for (genvar g = 0; g < NUM_WAYS; g++) begin : g_clr_rank
		assign clr_ranks[g] = RANK_W'(g);
	end
	assign clr_row = {clr_ranks, {STS_W{1'b0}}, {TAGS_W{1'b0}}};

	// clearing pass after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_active_q <= 1'b1;
			clr_addr_q   <= '0;
		end else if (clr_active_q) begin
			if (clr_addr_q == SET_AW'(NUM_SETS - 1)) begin
				clr_active_q <= 1'b0;
			end
			clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	// access stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			fwd_s1   <= 1'b0;
		end else begin
			valid_s1 <= accept;
			fwd_s1   <= accept && valid_s1 && (rd_addr == addr_s1);
		end
	end

	// access stage payload, forwarded row for back-to-back same-set accesses
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1      <= operation;
			tag_s1     <= TAG_WIDTH'(line_tag);
			ns_s1      <= new_state;
			addr_s1    <= rd_addr;
			fwd_row_s1 <= upd_row;
		end
	end

	// memory read and write ports
	assign mem_we    = clr_active_q || valid_s1;
	assign mem_waddr = clr_active_q ? clr_addr_q : addr_s1;
	assign mem_wdata = clr_active_q ? clr_row : upd_row;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			row_mem[mem_waddr] <= mem_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_row_s1 <= row_mem[rd_addr];
		end
	end

	// current row and its fields
	assign cur_row = fwd_s1 ? fwd_row_s1 : rd_row_s1;
	assign {cur_ranks, cur_states, cur_tags} = cur_row;
	assign upd_row = {upd_ranks, upd_states, upd_tags};

	sal_row_update #(
		.NUM_WAYS  (NUM_WAYS),
		.TAG_WIDTH (TAG_WIDTH),
		.RANK_W    (RANK_W)
	) u_row_update (
		.operation  (op_s1),
		.tag        (tag_s1),
		.new_state  (ns_s1),
		.tags       (cur_tags),
		.states     (cur_states),
		.ranks      (cur_ranks),
		.new_tags   (upd_tags),
		.new_states (upd_states),
		.new_ranks  (upd_ranks),
		.result     (res)
	);

	// result word strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s1;
		end
	end

	// result word payload
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			hit          <= res.hit;
			found_state  <= res.found_state;
			victim_valid <= res.victim_valid;
			victim_tag   <= res.victim_tag;
			victim_dirty <= res.victim_dirty;
		end
	end

	assign done = done_q;

	// every access in the update stage yields exactly one result word
	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |=> done_q)
		else $error("access in update stage produced no result word");

	a_no_spurious_done: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |=> !done_q)
		else $error("result word without an access");

	// no access may be in flight while the clearing pass owns the memory
	a_clear_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		clr_active_q |-> !valid_s1)
		else $error("access overlaps the clearing pass");

	// forwarding only ever serves an access in the update stage
	a_fwd_valid: assert property (@(posedge clk) disable iff (!arst_n)
		fwd_s1 |-> valid_s1)
		else $error("forwarded row without an access");

	// an eviction only comes from an insert that missed
	a_victim_insert: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && res.victim_valid |-> op_s1 == OP_INSERT && !res.hit)
		else $error("eviction outside an inserting miss");

endmodule

// File: src/sal_row_update.sv
// tag match, victim choice and lru rank update over one set row
module sal_row_update #(
	parameter int NUM_WAYS  = 4,
	parameter int TAG_WIDTH = 20,
	parameter int RANK_W    = 2
) (
	input  logic [sal_pkg::OP_W-1:0]                   operation,
	input  logic [TAG_WIDTH-1:0]                       tag,
	input  logic [sal_pkg::STATE_W-1:0]                new_state,
	input  logic [NUM_WAYS-1:0][TAG_WIDTH-1:0]         tags,
	input  logic [NUM_WAYS-1:0][sal_pkg::STATE_W-1:0]  states,
	input  logic [NUM_WAYS-1:0][RANK_W-1:0]            ranks,
	output logic [NUM_WAYS-1:0][TAG_WIDTH-1:0]         new_tags,
	output logic [NUM_WAYS-1:0][sal_pkg::STATE_W-1:0]  new_states,
	output logic [NUM_WAYS-1:0][RANK_W-1:0]            new_ranks,
	output sal_pkg::sal_result_t                       result
);
	import sal_pkg::*;

	logic              hit;
	logic [RANK_W-1:0] hit_w;
	logic              free;
	logic [RANK_W-1:0] free_w;
	logic [RANK_W-1:0] lru_w;
	logic [RANK_W-1:0] slot;
	logic              ns_ok;
	logic              st_en;
	logic [RANK_W-1:0] st_way;
	logic              mru_en;
	logic [RANK_W-1:0] mru_way;
	logic              ins;
	logic              evict;
	logic [RANK_W-1:0] old_rank;

	// per-way search: lowest matching way, lowest free way, lru way
	always_comb begin
		hit    = 1'b0;
		hit_w  = '0;
		free   = 1'b0;
		free_w = '0;
		lru_w  = '0;
		for (int w = NUM_WAYS - 1; w >= 0; w--) begin
			if (states[w] != ST_INVALID && tags[w] == tag) begin
				hit   = 1'b1;
				hit_w = RANK_W'(w);
			end
			if (states[w] == ST_INVALID) begin
				free   = 1'b1;
				free_w = RANK_W'(w);
			end
			if (ranks[w] == RANK_W'(NUM_WAYS - 1)) begin
				lru_w = RANK_W'(w);
			end
		end
	end

	assign slot  = free ? free_w : lru_w;
	assign ns_ok = (new_state <= ST_MODIFIED);

	// decide which fields of the row change
	always_comb begin
		st_en   = 1'b0;
		st_way  = hit_w;
		mru_en  = 1'b0;
		mru_way = hit_w;
		ins     = 1'b0;
		evict   = 1'b0;
		case (operation)
			OP_LOOKUP: begin
			end
			OP_SET_STATE: begin
				st_en = hit && ns_ok;
			end
			OP_TOUCH: begin
				mru_en = hit;
			end
			OP_INSERT: begin
				if (ns_ok) begin
					if (hit) begin
						st_en  = 1'b1;
						mru_en = (new_state != ST_INVALID);
					end else if (new_state != ST_INVALID) begin
						ins     = 1'b1;
						evict   = !free;
						st_en   = 1'b1;
						st_way  = slot;
						mru_en  = 1'b1;
						mru_way = slot;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// build the row to write back; mru promotion ages the younger ways by one
	assign old_rank = ranks[mru_way];

	always_comb begin
		new_tags   = tags;
		new_states = states;
		new_ranks  = ranks;
		if (ins) begin
			new_tags[slot] = tag;
		end
		if (st_en) begin
			new_states[st_way] = new_state;
		end
		if (mru_en) begin
			for (int v = 0; v < NUM_WAYS; v++) begin
				if (ranks[v] < old_rank) begin
					new_ranks[v] = ranks[v] + 1'b1;
				end
			end
			new_ranks[mru_way] = '0;
		end
	end

	// result word
	always_comb begin
		result.hit          = hit;
		result.found_state  = hit ? states[hit_w] : ST_INVALID;
		result.victim_valid = evict;
		result.victim_tag   = evict ? OUT_TAG_W'(tags[lru_w]) : '0;
		result.victim_dirty = evict &&
			(states[lru_w] == ST_MODIFIED || states[lru_w] == ST_OWNED);
	end

endmodule
